// ===== hdl/i4dq_pkg.sv =====
// ----------------------------------------------------------------------------
// i4dq_pkg
// shared types and constants for the int4 grouped dequant dot block
// ----------------------------------------------------------------------------
package i4dq_pkg;

    localparam int NIBBLES         = 8;
    localparam int NIB_W           = 4;
    localparam int WORD_W          = NIBBLES * NIB_W;
    localparam int ACT_W           = 16;
    localparam int SCALE_W         = 16;
    localparam int SCALE_FRAC_BITS = 16;
    // signed 4-bit weight times 16-bit activation
    localparam int PROD_W          = NIB_W + ACT_W;
    // eight products summed
    localparam int PART_W          = PROD_W + 3;
    // word sum times unsigned scale
    localparam int SCALED_W        = PART_W + SCALE_W + 1;
    localparam int SUM_W           = 56;
    localparam int OUT_W           = 32;
    // rounded accumulator, one guard bit for the rounding add
    localparam int RND_W           = SUM_W + 1 - SCALE_FRAC_BITS;

    // nibble decode is nibble minus 8, i.e. flip the top bit
    localparam logic [NIB_W-1:0] NIB_FLIP = 4'h8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SUM,
        ST_SCALE,
        ST_ACCUM,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_prod;
        logic calc_sum;
        logic calc_scale;
        logic accum;
        logic round_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/i4dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// i4dq_ctrl
// sequencer that steps one request at a time through the datapath
// ----------------------------------------------------------------------------
module i4dq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i4dq_pkg::t_dp_stat  i_stat,
    output i4dq_pkg::t_dp_cmd   o_cmd
);

    i4dq_pkg::t_state r_state;
    i4dq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i4dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            i4dq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i4dq_pkg::ST_PROD;
                end
            end
            i4dq_pkg::ST_PROD:  n_state = i4dq_pkg::ST_SUM;
            i4dq_pkg::ST_SUM:   n_state = i4dq_pkg::ST_SCALE;
            i4dq_pkg::ST_SCALE: n_state = i4dq_pkg::ST_ACCUM;
            i4dq_pkg::ST_ACCUM: begin
                n_state = i_stat.last ? i4dq_pkg::ST_ROUND : i4dq_pkg::ST_IDLE;
            end
            i4dq_pkg::ST_ROUND: begin
                if (i_stat.out_free) begin
                    n_state = i4dq_pkg::ST_IDLE;
                end
            end
            default: n_state = i4dq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            i4dq_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            i4dq_pkg::ST_PROD:  o_cmd.calc_prod  = 1'b1;
            i4dq_pkg::ST_SUM:   o_cmd.calc_sum   = 1'b1;
            i4dq_pkg::ST_SCALE: o_cmd.calc_scale = 1'b1;
            i4dq_pkg::ST_ACCUM: o_cmd.accum      = 1'b1;
            i4dq_pkg::ST_ROUND: o_cmd.round_out  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/i4dq_dp.sv =====
// ----------------------------------------------------------------------------
// i4dq_dp
// decode, multiply, scale, accumulate and round datapath with output register
// ----------------------------------------------------------------------------
module i4dq_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  i4dq_pkg::t_dp_cmd                      i_cmd,
    output i4dq_pkg::t_dp_stat                     o_stat,
    input  logic        [i4dq_pkg::WORD_W-1:0]     i_packed_weights,
    input  logic signed [i4dq_pkg::ACT_W-1:0]      i_act [i4dq_pkg::NIBBLES],
    input  logic        [i4dq_pkg::SCALE_W-1:0]    i_group_scale,
    input  logic                                   i_last_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [i4dq_pkg::OUT_W-1:0]      o_dot_result,
    output logic                                   o_saturated
);

    localparam int NIB  = i4dq_pkg::NIBBLES;
    localparam int PW   = i4dq_pkg::PROD_W;
    localparam int QW   = i4dq_pkg::PART_W;
    localparam int XW   = i4dq_pkg::SCALED_W;
    localparam int SW   = i4dq_pkg::SUM_W;
    localparam int RW   = i4dq_pkg::RND_W;
    localparam int OW   = i4dq_pkg::OUT_W;
    localparam int FB   = i4dq_pkg::SCALE_FRAC_BITS;

    // captured request
    logic        [i4dq_pkg::WORD_W-1:0]  r_weights;
    logic signed [i4dq_pkg::ACT_W-1:0]   r_act [NIB];
    logic        [i4dq_pkg::SCALE_W-1:0] r_scale;
    logic                                r_last;

    logic signed [PW-1:0] r_prod [NIB];
    logic signed [PW-1:0] n_prod [NIB];
    logic signed [QW-1:0] r_part;
    logic signed [QW-1:0] n_part;
    logic signed [XW-1:0] r_scaled;
    logic signed [XW-1:0] n_scaled;

    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic                 r_clamped;
    logic                 n_clamped;

    logic                 r_out_valid;
    logic signed [OW-1:0] r_dot;
    logic signed [OW-1:0] n_dot;
    logic                 r_sat;
    logic                 n_sat;

    logic signed [SW:0]   sum_wide;
    logic signed [SW:0]   rnd_wide;
    logic signed [RW-1:0] rnd_val;
    logic                 out_free;

    always_comb begin
        logic signed [i4dq_pkg::NIB_W-1:0] w;
        for (int j = 0; j < NIB; j++) begin
            w = $signed(r_weights[j*i4dq_pkg::NIB_W +: i4dq_pkg::NIB_W] ^ i4dq_pkg::NIB_FLIP);
            n_prod[j] = PW'(w) * PW'(r_act[j]);
        end
    end

    always_comb begin
        n_part = '0;
        for (int j = 0; j < NIB; j++) begin
            n_part = n_part + QW'(r_prod[j]);
        end
    end

    assign n_scaled = XW'(r_part) * XW'($signed({1'b0, r_scale}));

    // saturating accumulate, overflow when the two top bits disagree
    always_comb begin
        sum_wide  = (SW+1)'(r_sum) + (SW+1)'(r_scaled);
        n_sum     = sum_wide[SW-1:0];
        n_clamped = r_clamped;
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            n_sum     = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            n_clamped = 1'b1;
        end
    end

    // round to nearest, ties up, then clamp to output range
    always_comb begin
        rnd_wide = (SW+1)'(r_sum) + ((SW+1)'(1) <<< (FB-1));
        rnd_val  = rnd_wide[SW:FB];
        n_dot    = rnd_val[OW-1:0];
        n_sat    = r_clamped;
        if (rnd_val[RW-1:OW-1] != {(RW-OW+1){rnd_val[OW-1]}}) begin
            n_dot = rnd_val[RW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
            n_sat = 1'b1;
        end
    end

    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_weights <= i_packed_weights;
            r_act     <= i_act;
            r_scale   <= i_group_scale;
            r_last    <= i_last_word;
        end
        if (i_cmd.calc_prod) begin
            r_prod <= n_prod;
        end
        if (i_cmd.calc_sum) begin
            r_part <= n_part;
        end
        if (i_cmd.calc_scale) begin
            r_scaled <= n_scaled;
        end
        if (i_cmd.round_out) begin
            r_dot <= n_dot;
            r_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_clamped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum     <= n_sum;
                r_clamped <= n_clamped;
            end else if (i_cmd.round_out) begin
                r_sum     <= '0;
                r_clamped <= 1'b0;
            end
            if (i_cmd.round_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dot_result = r_dot;
    assign o_saturated  = r_sat;

endmodule

// ===== hdl/int4_grouped_dequant_dot.sv =====
// ----------------------------------------------------------------------------
// int4_grouped_dequant_dot
// one output of a 4-bit-weight gemv: dequantize, dot, scale and accumulate
// ----------------------------------------------------------------------------
// path: an accepted word passes the product, word sum and scaled registers
//   into the accumulator; a last word then rounds into the output register
// flow: one word at a time, the next taken only when the sequencer is back
//   in idle; the round step also waits while the output register is stalled
// reset: synchronous active low, clears the sequencer, accumulator, sticky
//   clamp flag and output valid
module int4_grouped_dequant_dot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [i4dq_pkg::WORD_W-1:0]  i_packed_weights,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_0,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_1,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_2,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_3,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_4,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_5,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_6,
    input  logic signed [i4dq_pkg::ACT_W-1:0]   i_act_7,
    input  logic        [i4dq_pkg::SCALE_W-1:0] i_group_scale,
    input  logic                                i_last_word,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [i4dq_pkg::OUT_W-1:0]   o_dot_result,
    output logic                                o_saturated
);

    // command and status between sequencer and datapath
    i4dq_pkg::t_dp_cmd  cmd;
    i4dq_pkg::t_dp_stat stat;

    // activations gathered into a lane array, lane j pairs with nibble j
    logic signed [i4dq_pkg::ACT_W-1:0] act [i4dq_pkg::NIBBLES];

    assign act[0] = i_act_0;
    assign act[1] = i_act_1;
    assign act[2] = i_act_2;
    assign act[3] = i_act_3;
    assign act[4] = i_act_4;
    assign act[5] = i_act_5;
    assign act[6] = i_act_6;
    assign act[7] = i_act_7;

    // sequencer: idle -> products -> word sum -> scale -> accumulate,
    // then a round step on the last word of a dot product
    i4dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath holds the 56-bit saturating accumulator and the output
    // register, so a finished result can wait while the next word is taken
    i4dq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_packed_weights (i_packed_weights),
        .i_act            (act),
        .i_group_scale    (i_group_scale),
        .i_last_word      (i_last_word),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_dot_result     (o_dot_result),
        .o_saturated      (o_saturated)
    );

endmodule
